// ===== src/drmt_pkg.sv =====
// shared types and codes for the dirty range merge table
package drmt_pkg;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_COMPRESS = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_MERGED_NEXT = 3'd1;
  localparam logic [2:0] ST_MERGED_PREV = 3'd2;
  localparam logic [2:0] ST_ZERO        = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic [2:0] ST_ENTRY       = 3'd5;
  localparam logic [2:0] ST_EMPTY       = 3'd6;
  localparam logic [2:0] ST_CLEARED     = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_APPLY,
    S_WSTART,
    S_WALK
  } state_t;

  typedef enum logic [2:0] {
    PH_HOLD,
    PH_FIND,
    PH_NEXT,
    PH_PREV,
    PH_INS,
    PH_WALK
  } cell_phase_t;

  typedef struct packed {
    cell_phase_t phase;
    logic        pop;
    logic        push;
    logic        any_gt;
  } cell_ctrl_t;

endpackage

// ===== src/drmt_join.sv =====
// reach test and merged length of two ranges, left one first
module drmt_join
  import drmt_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  logic [OFFSET_BITS-1:0] a_off,
  input  logic [OFFSET_BITS:0]   a_len,
  input  logic [OFFSET_BITS-1:0] b_off,
  input  logic [OFFSET_BITS:0]   b_len,
  output logic                   reach,
  output logic [OFFSET_BITS:0]   len
);

  logic [OFFSET_BITS+1:0] a_end;
  logic [OFFSET_BITS+1:0] b_end;
  logic [OFFSET_BITS+1:0] a_off_x;
  logic [OFFSET_BITS+1:0] ext;

  assign a_off_x = {2'b00, a_off};
  assign a_end   = a_off_x + {1'b0, a_len};
  assign b_end   = {2'b00, b_off} + {1'b0, b_len};
  assign reach   = ({2'b00, b_off} <= a_end);
  assign ext     = (b_end > a_off_x) ? (b_end - a_off_x) : '0;
  assign len     = ({1'b0, a_len} > ext) ? a_len : ext[OFFSET_BITS:0];

endmodule

// ===== src/drmt_cell.sv =====
// one table slot of the sorted range chain
module drmt_cell
  import drmt_pkg::*;
#(
  parameter int OFFSET_BITS = 16,
  parameter int CW          = 6,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctrl_t             ctrl,
  input  logic [CW-1:0]          count,
  input  logic [CW-1:0]          wpos,
  input  logic [OFFSET_BITS-1:0] d_off,
  input  logic [OFFSET_BITS:0]   d_len,
  input  logic [OFFSET_BITS-1:0] push_off,
  input  logic [OFFSET_BITS:0]   push_len,
  input  logic [OFFSET_BITS-1:0] left_off,
  input  logic [OFFSET_BITS:0]   left_len,
  input  logic                   left_gt,
  input  logic [OFFSET_BITS-1:0] right_off,
  input  logic [OFFSET_BITS:0]   right_len,
  input  logic                   right_gt,
  input  logic                   right_valid,
  output logic [OFFSET_BITS-1:0] off,
  output logic [OFFSET_BITS:0]   len,
  output logic                   gt_now,
  output logic                   valid,
  output logic                   gt_flag,
  output logic                   hit_next,
  output logic                   hit_prev
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS:0]   len_r, len_nxt;
  logic gt_r, gt_nxt, pos_r, pos_nxt, prev_r, prev_nxt;
  logic hn_r, hn_nxt, hp_r, hp_nxt;
  logic is_pos, is_prev, rn, rp;
  logic [OFFSET_BITS:0] ln, lp;

  drmt_join #(.OFFSET_BITS(OFFSET_BITS)) u_jn (
    .a_off(d_off), .a_len(d_len), .b_off(off_r), .b_len(len_r), .reach(rn), .len(ln)
  );
  drmt_join #(.OFFSET_BITS(OFFSET_BITS)) u_jp (
    .a_off(off_r), .a_len(len_r), .b_off(d_off), .b_len(d_len), .reach(rp), .len(lp)
  );

  assign valid   = (IDX_C < count);
  assign gt_now  = valid && (off_r > d_off);
  assign is_pos  = gt_now && !left_gt;
  assign is_prev = valid && !gt_now && (!right_valid || right_gt);

  always_comb begin
    off_nxt  = off_r;
    len_nxt  = len_r;
    gt_nxt   = gt_r;
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    hn_nxt   = hn_r;
    hp_nxt   = hp_r;
    unique case (ctrl.phase)
      PH_FIND: begin
        gt_nxt   = gt_now;
        pos_nxt  = is_pos;
        prev_nxt = is_prev;
        hn_nxt   = is_pos && rn;
        hp_nxt   = is_prev && rp;
      end
      PH_NEXT: begin
        if (pos_r) begin
          off_nxt = d_off;
          len_nxt = ln;
        end
      end
      PH_PREV: begin
        if (prev_r) len_nxt = lp;
      end
      PH_INS: begin
        if (pos_r || (!ctrl.any_gt && IDX_C == count)) begin
          off_nxt = d_off;
          len_nxt = d_len;
        end else if ((gt_r && !pos_r) || (ctrl.any_gt && IDX_C == count)) begin
          off_nxt = left_off;
          len_nxt = left_len;
        end
      end
      PH_WALK: begin
        if (ctrl.push && IDX_C == wpos) begin
          off_nxt = push_off;
          len_nxt = push_len;
        end else if (ctrl.pop) begin
          off_nxt = right_off;
          len_nxt = right_len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    len_r <= len_nxt;
    if (!rst_n) begin
      gt_r   <= 1'b0;
      pos_r  <= 1'b0;
      prev_r <= 1'b0;
      hn_r   <= 1'b0;
      hp_r   <= 1'b0;
    end else begin
      gt_r   <= gt_nxt;
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
      hn_r   <= hn_nxt;
      hp_r   <= hp_nxt;
    end
  end

  assign off      = off_r;
  assign len      = len_r;
  assign gt_flag  = gt_r;
  assign hit_next = hn_r;
  assign hit_prev = hp_r;

endmodule

// ===== src/dirty_range_merge_table.sv =====
// dirty range merge table: sorted chain of range cells with insert, compress and clear
//
// command port: start with in_operation, in_range_offset, in_range_size is taken
// when busy is low. insert (size nonzero) latches the range, then every cell
// compares itself to the new range, then the chain is merged or shifted. a zero
// size insert, clear and compress on an empty table answer in the next cycle and
// leave busy low. in compress the chain pops one entry per cycle into a merge
// accumulator, and each finished entry is emitted and pushed back into the chain
// behind the unread ones. an unused operation code gets no answer.
// results come on out_status, out_entry_offset, out_entry_size, out_last for one
// cycle under out_valid; out_last marks the final beat of a command. the receiver
// cannot stall; the block never emits more than one beat per cycle.
// reset empties the table (count zero); slot contents are not cleared.
module dirty_range_merge_table
  import drmt_pkg::*;
#(
  parameter int MAX_RANGES  = 32,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_operation,
  input  logic [OFFSET_BITS-1:0] in_range_offset,
  input  logic [OFFSET_BITS-1:0] in_range_size,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [OFFSET_BITS-1:0] out_entry_offset,
  output logic [OFFSET_BITS:0]   out_entry_size,
  output logic                   out_last
);

  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_RANGES);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, rem_r, rem_nxt, wcnt_r, wcnt_nxt;
  logic [OFFSET_BITS-1:0] d_off_r, d_off_nxt, acc_off_r, acc_off_nxt;
  logic [OFFSET_BITS:0]   d_len_r, d_len_nxt, acc_len_r, acc_len_nxt;
  logic                   ov_r, ov_nxt, ol_r, ol_nxt;
  logic [2:0]             os_r, os_nxt;
  logic [OFFSET_BITS-1:0] oo_r, oo_nxt;
  logic [OFFSET_BITS:0]   oz_r, oz_nxt;
  cell_ctrl_t ctrl;
  logic [CW-1:0] wpos;

  logic [OFFSET_BITS-1:0] c_off [MAX_RANGES];
  logic [OFFSET_BITS:0]   c_len [MAX_RANGES];
  logic [MAX_RANGES-1:0]  c_gtn, c_val, c_gt, c_hn, c_hp;
  logic any_gt, hit_next, hit_prev, acc_reach;
  logic [OFFSET_BITS:0] acc_join;

  assign any_gt   = |c_gt;
  assign hit_next = |c_hn;
  assign hit_prev = |c_hp;

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    logic [OFFSET_BITS-1:0] l_off, r_off;
    logic [OFFSET_BITS:0]   l_len, r_len;
    logic                   l_gt, r_gt, r_val;
    if (i == 0) begin : g_l0
      assign l_off = '0;
      assign l_len = '0;
      assign l_gt  = 1'b0;
    end else begin : g_ln
      assign l_off = c_off[i-1];
      assign l_len = c_len[i-1];
      assign l_gt  = c_gtn[i-1];
    end
    if (i == MAX_RANGES - 1) begin : g_r0
      assign r_off = '0;
      assign r_len = '0;
      assign r_gt  = 1'b0;
      assign r_val = 1'b0;
    end else begin : g_rn
      assign r_off = c_off[i+1];
      assign r_len = c_len[i+1];
      assign r_gt  = c_gtn[i+1];
      assign r_val = c_val[i+1];
    end
    drmt_cell #(.OFFSET_BITS(OFFSET_BITS), .CW(CW), .IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .count(count_r), .wpos(wpos),
      .d_off(d_off_r), .d_len(d_len_r), .push_off(acc_off_r), .push_len(acc_len_r),
      .left_off(l_off), .left_len(l_len), .left_gt(l_gt),
      .right_off(r_off), .right_len(r_len), .right_gt(r_gt), .right_valid(r_val),
      .off(c_off[i]), .len(c_len[i]), .gt_now(c_gtn[i]), .valid(c_val[i]),
      .gt_flag(c_gt[i]), .hit_next(c_hn[i]), .hit_prev(c_hp[i])
    );
  end

  // accumulator against the head of the chain during compress
  drmt_join #(.OFFSET_BITS(OFFSET_BITS)) u_acc_join (
    .a_off(acc_off_r), .a_len(acc_len_r), .b_off(c_off[0]), .b_len(c_len[0]),
    .reach(acc_reach), .len(acc_join)
  );

  assign wpos = (rem_r == '0) ? wcnt_r : (rem_r - 1'b1 + wcnt_r);
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    wcnt_nxt    = wcnt_r;
    d_off_nxt   = d_off_r;
    d_len_nxt   = d_len_r;
    acc_off_nxt = acc_off_r;
    acc_len_nxt = acc_len_r;
    ov_nxt      = 1'b0;
    os_nxt      = os_r;
    oo_nxt      = '0;
    oz_nxt      = '0;
    ol_nxt      = 1'b1;
    ctrl        = '{phase: PH_HOLD, pop: 1'b0, push: 1'b0, any_gt: any_gt};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority case (in_operation)
            OP_INSERT: begin
              if (in_range_size == '0) begin
                ov_nxt = 1'b1;
                os_nxt = ST_ZERO;
              end else begin
                d_off_nxt = in_range_offset;
                d_len_nxt = {1'b0, in_range_size};
                state_nxt = S_FIND;
              end
            end
            OP_COMPRESS: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1;
                os_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_WSTART;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              ov_nxt    = 1'b1;
              os_nxt    = ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        ctrl.phase = PH_FIND;
        state_nxt  = S_APPLY;
      end
      S_APPLY: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        if (hit_next) begin
          ctrl.phase = PH_NEXT;
          os_nxt     = ST_MERGED_NEXT;
        end else if (hit_prev) begin
          ctrl.phase = PH_PREV;
          os_nxt     = ST_MERGED_PREV;
        end else if (count_r == MAX_C) begin
          os_nxt = ST_FULL;
        end else begin
          ctrl.phase = PH_INS;
          os_nxt     = ST_INSERTED;
          count_nxt  = count_r + 1'b1;
        end
      end
      S_WSTART: begin
        ctrl.phase  = PH_WALK;
        ctrl.pop    = 1'b1;
        acc_off_nxt = c_off[0];
        acc_len_nxt = c_len[0];
        rem_nxt     = count_r - 1'b1;
        wcnt_nxt    = '0;
        state_nxt   = S_WALK;
      end
      S_WALK: begin
        ctrl.phase = PH_WALK;
        os_nxt     = ST_ENTRY;
        oo_nxt     = acc_off_r;
        oz_nxt     = acc_len_r;
        if (rem_r == '0) begin
          ctrl.push = 1'b1;
          ov_nxt    = 1'b1;
          count_nxt = wcnt_r + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ctrl.pop = 1'b1;
          rem_nxt  = rem_r - 1'b1;
          if (acc_reach) begin
            acc_len_nxt = acc_join;
          end else begin
            // finished entry goes out and back behind the unread ones
            ctrl.push   = 1'b1;
            ov_nxt      = 1'b1;
            ol_nxt      = 1'b0;
            acc_off_nxt = c_off[0];
            acc_len_nxt = c_len[0];
            wcnt_nxt    = wcnt_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    d_off_r   <= d_off_nxt;
    d_len_r   <= d_len_nxt;
    acc_off_r <= acc_off_nxt;
    acc_len_r <= acc_len_nxt;
    rem_r     <= rem_nxt;
    wcnt_r    <= wcnt_nxt;
    os_r      <= os_nxt;
    oo_r      <= oo_nxt;
    oz_r      <= oz_nxt;
    ol_r      <= ol_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_entry_offset = oo_r;
  assign out_entry_size   = oz_r;
  assign out_last         = ol_r;

endmodule

// ===== src/drmt_checker.sv =====
// port level checks for the dirty range merge table, bound to the top level
module drmt_checker
  import drmt_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic [1:0]             in_operation,
  input logic                   out_valid,
  input logic [2:0]             out_status,
  input logic [OFFSET_BITS-1:0] out_entry_offset,
  input logic [OFFSET_BITS:0]   out_entry_size,
  input logic                   out_last
);

  // an accepted insert either works on or answers at once
  a_insert_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_INSERT |=> busy || out_valid)
    else $error("insert neither busy nor answered");

  // every command that raises busy ends with a final beat exactly as busy drops
  a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_last)
    else $error("busy dropped without final beat");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ENTRY |-> out_last)
    else $error("non-entry beat not last");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ENTRY |-> out_entry_offset == '0 && out_entry_size == '0)
    else $error("non-entry beat carries payload");

endmodule

bind dirty_range_merge_table drmt_checker #(.OFFSET_BITS(OFFSET_BITS)) u_drmt_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_operation(in_operation),
  .out_valid(out_valid), .out_status(out_status), .out_entry_offset(out_entry_offset),
  .out_entry_size(out_entry_size), .out_last(out_last)
);

// ===== test/testbench.sv =====
// self-checking testbench for the dirty range merge table
`timescale 1ns / 1ps

module testbench;
  import drmt_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] entry_offset;
    logic [16:0] entry_size;
    logic        last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [15:0] in_range_offset;
  logic [15:0] in_range_size;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_entry_offset;
  logic [16:0] out_entry_size;
  logic        out_last;

  beat_t       pending_beats[$];
  int          range_start[TABLE_DEPTH];
  int          range_len[TABLE_DEPTH];
  int          range_count;
  int          errors;
  int          cycles;
  int          idle_pct;

  dirty_range_merge_table #(
    .MAX_RANGES(TABLE_DEPTH),
    .OFFSET_BITS(16)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_range_offset(in_range_offset),
    .in_range_size(in_range_size),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_entry_offset(out_entry_offset),
    .out_entry_size(out_entry_size),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int merged_len(int a_off, int a_len, int b_off, int b_len);
    int b_end;
    int ext;
    b_end = b_off + b_len;
    ext = (b_end > a_off) ? b_end - a_off : 0;
    return ((a_len > ext) ? a_len : ext) & 32'h1FFFF;
  endfunction

  function automatic beat_t mk_beat(logic [2:0] st, int off, int len, logic last);
    beat_t b;
    b.status = st;
    b.entry_offset = off[15:0];
    b.entry_size = len[16:0];
    b.last = last;
    return b;
  endfunction

  function automatic logic [2:0] apply_insert(int off, int len);
    int pos;
    pos = 0;
    if (len == 0) return ST_ZERO;
    while (pos < range_count && range_start[pos] <= off) pos++;
    if (pos < range_count && range_start[pos] <= off + len) begin
      range_len[pos] = merged_len(off, len, range_start[pos], range_len[pos]);
      range_start[pos] = off;
      return ST_MERGED_NEXT;
    end
    if (pos > 0 && off <= range_start[pos-1] + range_len[pos-1]) begin
      range_len[pos-1] = merged_len(range_start[pos-1], range_len[pos-1], off, len);
      return ST_MERGED_PREV;
    end
    if (range_count >= TABLE_DEPTH) return ST_FULL;
    for (int i = range_count; i > pos; i--) begin
      range_start[i] = range_start[i-1];
      range_len[i] = range_len[i-1];
    end
    range_start[pos] = off;
    range_len[pos] = len;
    range_count++;
    return ST_INSERTED;
  endfunction

  task automatic predict_command(logic [1:0] op, logic [15:0] off, logic [15:0] size);
    int w;
    w = 0;
    case (op)
      OP_INSERT: begin
        pending_beats.push_back(mk_beat(apply_insert(int'(off), int'(size)), 0, 0, 1'b1));
      end
      OP_COMPRESS: begin
        // single walk, joins touching neighbors only
        if (range_count > 1) begin
          for (int r = 1; r < range_count; r++) begin
            if (range_start[r] <= range_start[w] + range_len[w]) begin
              range_len[w] = merged_len(range_start[w], range_len[w],
                                        range_start[r], range_len[r]);
            end else begin
              w++;
              range_start[w] = range_start[r];
              range_len[w] = range_len[r];
            end
          end
          range_count = w + 1;
        end
        if (range_count == 0) pending_beats.push_back(mk_beat(ST_EMPTY, 0, 0, 1'b1));
        for (int i = 0; i < range_count; i++)
          pending_beats.push_back(mk_beat(ST_ENTRY, range_start[i], range_len[i],
                                          i == range_count - 1));
      end
      OP_CLEAR: begin
        range_count = 0;
        pending_beats.push_back(mk_beat(ST_CLEARED, 0, 0, 1'b1));
      end
      default: ;
    endcase
  endtask

  // result checker: the block cannot be stalled, so every strobe is a beat
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid) begin
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat: status %0d offset %0h size %0h last %0b", $time,
                 out_status, out_entry_offset, out_entry_size, out_last);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (out_status !== want.status) begin
          $display("%0t status: expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_entry_offset !== want.entry_offset) begin
          $display("%0t entry_offset: expected %0h actual %0h", $time,
                   want.entry_offset, out_entry_offset);
          errors++;
        end
        if (out_entry_size !== want.entry_size) begin
          $display("%0t entry_size: expected %0h actual %0h", $time,
                   want.entry_size, out_entry_size);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t last: expected %0b actual %0b", $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  task automatic send_command(logic [1:0] op, logic [15:0] off, logic [15:0] size);
    // idle cycle by cycle at the chosen share
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_range_offset <= off;
    in_range_size <= size;
    do @(posedge clk); while (busy);
    predict_command(op, off, size);
  endtask

  task automatic test_directed();
    send_command(OP_COMPRESS, 16'h0, 16'h0);      // empty readout
    send_command(OP_INSERT, 16'h1234, 16'h0);     // zero size
    send_command(OP_INSERT, 16'h0100, 16'h0010);
    send_command(OP_INSERT, 16'h00F0, 16'h0010);  // touches next
    send_command(OP_INSERT, 16'h0108, 16'h0020);  // overlaps previous
    send_command(OP_INSERT, 16'h0300, 16'h0004);
    send_command(OP_INSERT, 16'h0200, 16'h0100);  // reaches next
    send_command(OP_INSERT, 16'h0000, 16'h0001);
    send_command(OP_INSERT, 16'hFFFF, 16'hFFFF);  // widest end
    send_command(OP_INSERT, 16'h8000, 16'hFFFF);
    send_command(2'd3, 16'hFFFF, 16'hFFFF);       // unused operation
    send_command(OP_COMPRESS, 16'hFFFF, 16'hFFFF);
    send_command(OP_INSERT, 16'h0000, 16'hFFFF);
    send_command(OP_COMPRESS, 16'h0, 16'h0);
    send_command(OP_CLEAR, 16'h0, 16'h0);
    send_command(OP_COMPRESS, 16'h0, 16'h0);
  endtask

  task automatic test_full_table();
    send_command(OP_CLEAR, 16'h0, 16'h0);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_command(OP_INSERT, 16'(i * 8 + 4), 16'd2);
    send_command(OP_INSERT, 16'h4000, 16'd1);     // no room, dropped
    send_command(OP_INSERT, 16'h0000, 16'd2);     // dropped too
    send_command(OP_INSERT, 16'h0005, 16'd3);     // merge still works when full
    send_command(OP_INSERT, 16'h0002, 16'd2);
    send_command(OP_COMPRESS, 16'h0, 16'h0);
    send_command(OP_CLEAR, 16'h0, 16'h0);
  endtask

  task automatic test_random(int count);
    int pick;
    logic [15:0] off;
    logic [15:0] size;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      off = ($urandom_range(1)) ? 16'($urandom_range(0, 2047)) : 16'($urandom);
      case ($urandom_range(9))
        0: size = 16'h0;
        1: size = 16'($urandom);
        default: size = 16'($urandom_range(1, 64));
      endcase
      if (pick < 78) send_command(OP_INSERT, off, size);
      else if (pick < 90) send_command(OP_COMPRESS, off, size);
      else if (pick < 95) send_command(OP_CLEAR, off, size);
      else send_command(2'd3, off, size);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    range_count = 0;
    idle_pct = 34;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= OP_INSERT;
    in_range_offset <= '0;
    in_range_size <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_random(42);
    idle_pct = 74;
    test_random(42);
    idle_pct = 0;
    test_random(42);
    start <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
